// ----- hdl/ppmcd_pkg.sv -----
// shared types and constants of the ppm channel decoder
package ppmcd_pkg;

  // width of the running channel index
  localparam int unsigned ChanIdxW = 4;
  // quotient bits produced by the serial divider, one per cycle
  localparam int unsigned DivSteps = 15;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  // full scale of the q1.15 stick value
  localparam logic [14:0] Q15Max   = 15'h7fff;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PULSE_MIN    = 3'd0,
    CFG_PULSE_MID    = 3'd1,
    CFG_PULSE_MAX    = 3'd2,
    CFG_DEAD_BAND    = 3'd3,
    CFG_SYNC_GAP     = 3'd4,
    CFG_REVERSE_MASK = 3'd5
  } cfg_reg_e;

  // live configuration seen by front and back
  typedef struct packed {
    logic [11:0] pulse_min;
    logic [11:0] pulse_mid;
    logic [11:0] pulse_max;
    logic [9:0]  dead_band;
    logic [15:0] sync_gap;
    logic [7:0]  reverse_mask;
  } cfg_t;

  // one captured pulse handed from front to back
  typedef struct packed {
    logic [2:0]  chan;
    logic [11:0] raw;
    logic        rev;
  } job_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

endpackage

// ----- hdl/ppmcd_front.sv -----
// front end: edge timing, frame sync and channel classification
module ppmcd_front import ppmcd_pkg::*; #(
  parameter int unsigned NumChannels = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  logic [31:0] edge_time_i,
  output logic        stall_o,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [31:0]         last_q, last_d;
  logic [ChanIdxW-1:0] next_q, next_d;
  logic [31:0]         gap;
  logic                accept, is_sync, in_win, room, take;

  // input transfer only when the queue has room
  assign stall_o = q_stat_i.full;
  assign accept  = valid_i & ~q_stat_i.full;

  // gap classification
  assign gap     = edge_time_i - last_q;
  assign is_sync = gap > {16'b0, cfg_i.sync_gap};
  assign in_win  = (gap >= {20'b0, cfg_i.pulse_min}) && (gap <= {20'b0, cfg_i.pulse_max});
  assign room    = {1'b0, next_q} < (ChanIdxW+1)'(NumChannels);
  assign take    = ~is_sync & in_win & room;

  // job for the back end
  assign push_o    = accept & take;
  assign job_o.chan = next_q[2:0];
  assign job_o.raw  = gap[11:0];
  assign job_o.rev  = ~next_q[ChanIdxW-1] & cfg_i.reverse_mask[next_q[2:0]];

  // edge time and channel index update
  always_comb begin
    last_d = last_q;
    next_d = next_q;
    if (accept) begin
      last_d = edge_time_i;
      if (is_sync) begin
        next_d = '0;
      end else if (take) begin
        next_d = next_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      next_q <= '0;
    end else begin
      last_q <= last_d;
      next_q <= next_d;
    end
  end

endmodule

// ----- hdl/ppmcd_queue.sv -----
// two-entry job queue between front and back
module ppmcd_queue import ppmcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;
  assign job_o        = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- hdl/ppmcd_back.sv -----
// back end: dead band, serial scaling divider and result register
module ppmcd_back import ppmcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  q_stat_t            q_stat_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [2:0]         channel_number_o,
  output logic [11:0]        raw_width_o,
  output logic signed [15:0] stick_value_o
);

  back_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q;
  logic [11:0]        rem_q, d_q, raw_q;
  logic [14:0]        sh_q;
  logic [2:0]         chan_q;
  logic               flip_q;
  logic               out_valid_q;
  logic [2:0]         out_chan_q;
  logic [11:0]        out_raw_q;
  logic [15:0]        out_stick_q;

  logic signed [12:0] cen;
  logic               neg;
  logic [11:0]        mag, m;
  logic signed [13:0] den;
  logic               below_db, m_zero, den_nonpos, m_ge_d, trivial;
  logic [26:0]        numer;
  logic [12:0]        r2;
  logic               ge;
  logic [11:0]        rem_nx;
  logic               start, out_load;

  // centering, dead band and denominator of the head job
  always_comb begin
    cen = $signed({1'b0, job_i.raw}) - $signed({1'b0, cfg_i.pulse_mid});
    neg = cen[12];
    mag = neg ? 12'(-cen) : cen[11:0];
    below_db = mag < {2'b0, cfg_i.dead_band};
    m = mag - {2'b0, cfg_i.dead_band};
    m_zero = m == '0;
    if (neg) begin
      den = $signed({2'b0, cfg_i.pulse_mid}) - $signed({2'b0, cfg_i.pulse_min})
          - $signed({4'b0, cfg_i.dead_band});
    end else begin
      den = $signed({2'b0, cfg_i.pulse_max}) - $signed({2'b0, cfg_i.pulse_mid})
          - $signed({4'b0, cfg_i.dead_band});
    end
    den_nonpos = den[13] || (den == '0);
    m_ge_d = m >= den[11:0];
    trivial = below_db || m_zero || den_nonpos || m_ge_d;
    // m * 32767 as a shift and subtract
    numer = {m, 15'b0} - {15'b0, m};
  end

  // one restoring divide step
  always_comb begin
    r2     = {rem_q, sh_q[14]};
    ge     = r2 >= {1'b0, d_q};
    rem_nx = ge ? 12'(r2 - {1'b0, d_q}) : r2[11:0];
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    start    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          start   = 1'b1;
          state_d = trivial ? BK_DONE : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == '0) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || !stall_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign pop_o = start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        cnt_q <= DivCntW'(DivSteps - 1);
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (start) begin
      chan_q <= job_i.chan;
      raw_q  <= job_i.raw;
      flip_q <= neg ^ job_i.rev;
      d_q    <= den[11:0];
      rem_q  <= numer[26:15];
      if (below_db || m_zero) begin
        sh_q <= '0;
      end else if (den_nonpos || m_ge_d) begin
        sh_q <= Q15Max;
      end else begin
        sh_q <= numer[14:0];
      end
    end else if (state_q == BK_DIV) begin
      rem_q <= rem_nx;
      sh_q  <= {sh_q[13:0], ge};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q  <= chan_q;
      out_raw_q   <= raw_q;
      out_stick_q <= flip_q ? 16'(-{1'b0, sh_q}) : {1'b0, sh_q};
    end
  end

  assign valid_o          = out_valid_q;
  assign channel_number_o = out_chan_q;
  assign raw_width_o      = out_raw_q;
  assign stick_value_o    = $signed(out_stick_q);

endmodule

// ----- hdl/ppm_channel_decoder_top.sv -----
// top level of the ppm channel decoder: config registers, front, queue and back
// Each input transfer is the microsecond timestamp of a rising edge; the decoder measures the
// gap to the previous edge, restarts the frame on a gap above sync_gap and turns each remaining
// gap in [pulse_min, pulse_max], up to NUM_CHANNELS per frame, into one result with the channel
// index, the raw width and a signed q1.15 stick value. The front end takes one edge per cycle
// while its two-entry job queue has room. The back end scales a result through a setup step,
// DivSteps steps of the one-bit-per-cycle restoring divider and a result register load that
// waits out an output stall; a zero or full scale result skips the divider. It takes a new job
// only once the last is loaded. The user must write registers through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the block itself does not enforce it.
module ppm_channel_decoder_top import ppmcd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        edge_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         channel_number_o,
  output logic [11:0]        raw_width_o,
  output logic signed [15:0] stick_value_o
);

  cfg_t    cfg_q;
  logic    q_push, q_pop;
  job_t    q_wr_job, q_rd_job;
  q_stat_t q_stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min    <= 12'd1000;
      cfg_q.pulse_mid    <= 12'd1500;
      cfg_q.pulse_max    <= 12'd2000;
      cfg_q.dead_band    <= 10'd10;
      cfg_q.sync_gap     <= 16'd3000;
      cfg_q.reverse_mask <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PULSE_MIN:    cfg_q.pulse_min    <= cfg_data_i[11:0];
        CFG_PULSE_MID:    cfg_q.pulse_mid    <= cfg_data_i[11:0];
        CFG_PULSE_MAX:    cfg_q.pulse_max    <= cfg_data_i[11:0];
        CFG_DEAD_BAND:    cfg_q.dead_band    <= cfg_data_i[9:0];
        CFG_SYNC_GAP:     cfg_q.sync_gap     <= cfg_data_i;
        CFG_REVERSE_MASK: cfg_q.reverse_mask <= cfg_data_i[7:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // edge classification
  ppmcd_front #(
    .NumChannels (NUM_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (in_valid_i),
    .edge_time_i (edge_time_i),
    .stall_o     (in_stall_o),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .job_o       (q_wr_job)
  );

  // job queue
  ppmcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_wr_job),
    .pop_i  (q_pop),
    .job_o  (q_rd_job),
    .stat_o (q_stat)
  );

  // scaling and result output
  ppmcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_stat_i         (q_stat),
    .job_i            (q_rd_job),
    .pop_o            (q_pop),
    .valid_o          (out_valid_o),
    .stall_i          (out_stall_i),
    .channel_number_o (channel_number_o),
    .raw_width_o      (raw_width_o),
    .stick_value_o    (stick_value_o)
  );

`ifndef SYNTHESIS
  // the front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // the back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  // a pop is always followed by a busy back end, so no second pop next cycle
  a_single_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("back end popped two jobs in a row");

  // the stick value never reaches the most negative code
  a_stick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stick_value_o != 16'sh8000)
    else $error("stick value out of q1.15 range");
`endif

endmodule

// ----- tb/sv/ppm_channel_decoder_checker.sv -----
// checker of the ppm channel decoder: predicts channel readings and compares them at the output
module ppm_channel_decoder_checker import ppmcd_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [31:0]        edge_time_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         channel_number_i,
  input  logic [11:0]        raw_width_i,
  input  logic signed [15:0] stick_value_i,
  output int unsigned        fail_count_o,
  output int unsigned        readings_due_o
);

  // one decoded channel reading
  typedef struct packed {
    logic [2:0]         chan;
    logic [11:0]        raw;
    logic signed [15:0] stick;
  } reading_t;

  cfg_t                cfg_q;
  logic [31:0]         prev_edge_q;
  logic [ChanIdxW-1:0] chan_idx_q;
  reading_t            readings_q[$];
  int unsigned         fails;

  // center on mid, drop the dead band, scale to q1.15 and apply the reverse bit
  function automatic logic signed [15:0] scale_stick(logic [11:0] raw,
                                                     logic [ChanIdxW-1:0] chan, cfg_t cfg);
    int centered;
    int mag;
    int excess;
    int span;
    int quo;
    logic signed [15:0] val;
    centered = int'(raw) - int'(cfg.pulse_mid);
    mag = (centered < 0) ? -centered : centered;
    if (mag < int'(cfg.dead_band)) return '0;
    excess = mag - int'(cfg.dead_band);
    if (excess == 0) return '0;
    if (centered > 0) begin
      span = int'(cfg.pulse_max) - int'(cfg.pulse_mid) - int'(cfg.dead_band);
    end else begin
      span = int'(cfg.pulse_mid) - int'(cfg.pulse_min) - int'(cfg.dead_band);
    end
    // a span that is not positive saturates to full scale
    quo = int'(Q15Max);
    if (span > 0 && (excess * int'(Q15Max)) / span < quo) begin
      quo = (excess * int'(Q15Max)) / span;
    end
    val = 16'(quo);
    if (centered < 0) val = -val;
    if (chan < 8 && cfg.reverse_mask[chan[2:0]]) val = -val;
    return val;
  endfunction

  // watch transfers: compare results first, then predict from the new edge
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    logic [31:0] gap;
    if (!rst_ni) begin
      cfg_q = '{12'd1000, 12'd1500, 12'd2000, 10'd10, 16'd3000, 8'd0};
      prev_edge_q = '0;
      chan_idx_q = '0;
      readings_q.delete();
      fails = 0;
      fail_count_o <= 0;
      readings_due_o <= 0;
    end else begin
      // result transfer
      if (out_valid_i && !out_stall_i) begin
        got = '{channel_number_i, raw_width_i, stick_value_i};
        if (readings_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected reading, actual chan %0d raw %0d stick %0d", $time,
                   got.chan, got.raw, $signed(got.stick));
        end else begin
          want = readings_q.pop_front();
          if (got.chan !== want.chan || got.raw !== want.raw || got.stick !== want.stick) begin
            fails++;
            $display("%0t: reading mismatch, expected chan %0d raw %0d stick %0d, actual chan %0d raw %0d stick %0d",
                     $time, want.chan, want.raw, $signed(want.stick),
                     got.chan, got.raw, $signed(got.stick));
          end
        end
      end
      // edge transfer
      if (in_valid_i && !in_stall_i) begin
        gap = edge_time_i - prev_edge_q;
        prev_edge_q = edge_time_i;
        if (gap > 32'(cfg_q.sync_gap)) begin
          chan_idx_q = '0;
        end else if (gap >= 32'(cfg_q.pulse_min) && gap <= 32'(cfg_q.pulse_max) &&
                     int'(chan_idx_q) < NUM_CHANNELS) begin
          want.chan = chan_idx_q[2:0];
          want.raw = gap[11:0];
          want.stick = scale_stick(gap[11:0], chan_idx_q, cfg_q);
          readings_q.push_back(want);
          chan_idx_q = chan_idx_q + 1'b1;
        end
      end
      // register write
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PULSE_MIN:    cfg_q.pulse_min = cfg_data_i[11:0];
          CFG_PULSE_MID:    cfg_q.pulse_mid = cfg_data_i[11:0];
          CFG_PULSE_MAX:    cfg_q.pulse_max = cfg_data_i[11:0];
          CFG_DEAD_BAND:    cfg_q.dead_band = cfg_data_i[9:0];
          CFG_SYNC_GAP:     cfg_q.sync_gap = cfg_data_i;
          CFG_REVERSE_MASK: cfg_q.reverse_mask = cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      fail_count_o <= fails;
      readings_due_o <= readings_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_ppm_channel_decoder_top.sv -----
// testbench top of the ppm channel decoder: edge stimulus, output pacing and verdict
module tb_ppm_channel_decoder_top;
  import ppmcd_pkg::*;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomItems = 1900;
  localparam int unsigned NumPhases   = 12;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_idx = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        edge_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         channel_number;
  logic [11:0]        raw_width;
  logic signed [15:0] stick_value;
  int unsigned        fail_count;
  int unsigned        readings_due;

  // stimulus side knowledge of the live settings and the edge clock
  logic [31:0] now_t = '0;
  int unsigned pmin = 1000;
  int unsigned pmax = 2000;
  int unsigned psync = 3000;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 1'b0;
  logic        hold_req = 1'b0;

  ppm_channel_decoder_top #(
    .NUM_CHANNELS(NumChannels)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .edge_time_i     (edge_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .channel_number_o(channel_number),
    .raw_width_o     (raw_width),
    .stick_value_o   (stick_value)
  );

  ppm_channel_decoder_checker #(
    .NUM_CHANNELS(NumChannels)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .edge_time_i     (edge_time),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .channel_number_i(channel_number),
    .raw_width_i     (raw_width),
    .stick_value_i   (stick_value),
    .fail_count_o    (fail_count),
    .readings_due_o  (readings_due)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_ppm_channel_decoder_top failed");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on request, no random stalls while no_idle is set
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned r;
    bit          hold_seen;
    stall_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HoldCycles;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!no_idle && r < 20) begin
        out_stall <= 1'b1;
        stall_left = (r < 17) ? $urandom_range(0, 2) : $urandom_range(8, 29);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one register write, taken at the next edge
  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= 16'(value);
    @(posedge clk);
  endtask

  // hold the sender until every reading is out and the front has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // reprogram all registers while idle
  task automatic apply_settings(int unsigned lo, int unsigned mid, int unsigned hi,
                                int unsigned db, int unsigned sync, int unsigned mask);
    drain();
    write_reg(CFG_PULSE_MIN, lo);
    write_reg(CFG_PULSE_MID, mid);
    write_reg(CFG_PULSE_MAX, hi);
    write_reg(CFG_DEAD_BAND, db);
    write_reg(CFG_SYNC_GAP, sync);
    write_reg(CFG_REVERSE_MASK, mask);
    cfg_we <= 1'b0;
    pmin = lo;
    pmax = hi;
    psync = sync;
  endtask

  // offer one edge and wait for its transfer
  task automatic send_edge(logic [31:0] stamp);
    in_valid  <= 1'b1;
    edge_time <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  // random sender gap, mostly none or short
  task automatic pace();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic next_edge(int unsigned gap);
    now_t = now_t + 32'(gap);
    send_edge(now_t);
    pace();
  endtask

  task automatic jump_to(logic [31:0] stamp);
    now_t = stamp;
    send_edge(now_t);
    pace();
  endtask

  // sync gap then a run of pulses, some broken or out of range
  task automatic run_frame();
    int unsigned lo;
    int unsigned hi;
    int unsigned n;
    int unsigned r;
    lo = (pmin < pmax) ? pmin : pmax;
    hi = (pmin < pmax) ? pmax : pmin;
    r = $urandom_range(0, 99);
    next_edge(psync + 1 + ((r < 20) ? 0 : $urandom_range(0, 2000)));
    n = $urandom_range(1, 11);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 65) next_edge($urandom_range(lo, hi));
      else if (r < 77) next_edge(lo);
      else if (r < 89) next_edge(hi);
      else if (r < 95) next_edge((lo > 0 && r < 92) ? lo - 1 : hi + 1);
      else jump_to($urandom);
    end
    items_sent += n + 1;
  endtask

  // random settings, mostly well ordered, sometimes inverted or lopsided
  task automatic random_settings();
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned db;
    int unsigned sync;
    lo = $urandom_range(0, 3000);
    hi = $urandom_range(lo, 4095);
    mid = ($urandom_range(0, 99) < 80) ? $urandom_range(lo, hi) : $urandom_range(0, 4095);
    db = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 50) : $urandom_range(0, 1023);
    sync = ($urandom_range(0, 99) < 75) ? hi + $urandom_range(0, 3000)
                                        : $urandom_range(0, 65535);
    if ($urandom_range(0, 99) < 10) apply_settings(hi, mid, lo, db, sync, $urandom_range(0, 255));
    else apply_settings(lo, mid, hi, db, sync, $urandom_range(0, 255));
  endtask

  // main stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first edge from zero, limits, dead band, extra pulse, sync threshold
    next_edge(1500);
    next_edge(1000);
    next_edge(2000);
    next_edge(999);
    next_edge(2001);
    next_edge(1509);
    next_edge(1510);
    next_edge(1750);
    next_edge(1250);
    next_edge(1600);
    next_edge(1500);
    next_edge(3000);
    next_edge(3001);
    jump_to(32'hffff_f800);
    next_edge(1800);

    // span not positive above mid, all channels reversed
    apply_settings(1000, 1500, 1500, 10, 3000, 8'hff);
    next_edge(3001);
    next_edge(1510);
    next_edge(1511);
    next_edge(1000);

    // inverted limits: nothing is a pulse
    apply_settings(3000, 2000, 1000, 0, 5000, 8'h00);
    next_edge(5001);
    next_edge(1000);
    next_edge(2000);
    next_edge(3000);

    // sync threshold inside the pulse range
    apply_settings(1000, 1500, 2000, 10, 1200, 8'h00);
    next_edge(1201);
    next_edge(1100);
    next_edge(1300);
    next_edge(1150);

    // long receiver hold-off while the sender keeps offering pulses
    apply_settings(1000, 1500, 2000, 10, 3000, 8'h0f);
    no_idle = 1'b1;
    hold_req <= 1'b1;
    next_edge(3001);
    repeat (12) next_edge($urandom_range(1000, 2000));
    no_idle = 1'b0;

    // random frames over several settings, extremes first
    now_t = $urandom;
    items_sent = 0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: apply_settings(0, 0, 0, 0, 0, 8'h00);
        1: apply_settings(4095, 4095, 4095, 1023, 65535, 8'hff);
        2: apply_settings(0, 2048, 4095, 0, 65535, 8'haa);
        3: apply_settings(2, 2048, 4093, 1023, 4094, 8'h55);
        default: random_settings();
      endcase
      no_idle = (phase == 4 || phase == 9);
      while (items_sent < (phase + 1) * RandomItems / NumPhases) begin
        run_frame();
        // sender pause until everything is out
        if (phase == 7 && $urandom_range(0, 19) == 0) drain();
      end
    end
    no_idle = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("tb_ppm_channel_decoder_top passed");
    end else begin
      $display("tb_ppm_channel_decoder_top failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ppmcd_pkg.sv
hdl/ppmcd_front.sv
hdl/ppmcd_queue.sv
hdl/ppmcd_back.sv
hdl/ppm_channel_decoder_top.sv
tb/sv/ppm_channel_decoder_checker.sv
tb/sv/tb_ppm_channel_decoder_top.sv
